FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// When the trigger holds, the consequence must hold in the same cycle.
`define ASSERT_IMPLY(label, trig, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sstk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sortable stack package
// Operation codes, status codes and field widths of the sortable stack.
// ----------------------------------------------------------------------------
package sstk_pkg;

    localparam int DATA_W  = 32;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SORT = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic [DATA_W-1:0] NEG_ONE = '1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_POP_RD = 6'b000010,
        S_KEY_LD = 6'b000100,
        S_CMP    = 6'b001000,
        S_PLACE  = 6'b010000,
        S_RESP   = 6'b100000
    } state_t;

endpackage

FILE: hdl/sstk_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/sortable_stack_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sortable stack unit
// Last-in-first-out stack of signed 32-bit values with an in-place sort.
// ----------------------------------------------------------------------------
// Each input transfer carries one operation: push, pop, peek or sort, and
// produces exactly one result transfer. The entries sit in a single-port-read
// RAM of DEPTH words and one signed comparator serves the sort. A push goes
// straight to the result state; a pop or peek first passes S_POP_RD, since
// the RAM read is registered. A sort runs insertion sort, walking each key
// down with one compare per cycle; a sort of fewer than two entries goes
// straight to the result state. The next input is taken once the result
// sits in the output register.
module sortable_stack_unit
    import sstk_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mode[1:0], value[33:2], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // result_value[31:0], status[33:32],
                                   // entry_count[38:34], zero fill
);

    `include "assert_macros.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            i_reg, i_next;
    logic [AW-1:0]            j_reg, j_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic [DATA_W-1:0]        res_reg, res_next;
    logic [STAT_W-1:0]        st_reg, st_next;

    logic                     m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]        out_res_reg, out_res_next;
    logic [STAT_W-1:0]        out_st_reg, out_st_next;
    logic [COUNT_W-1:0]       out_cnt_reg, out_cnt_next;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [DATA_W-1:0]        mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic [DATA_W-1:0]        mem_rdata;

    logic                     s_accept;
    logic [MODE_W-1:0]        s_mode;
    logic [DATA_W-1:0]        s_value;
    logic [AW-1:0]            last_idx;
    logic                     above_key;
    logic                     out_free;

    assign s_mode   = s_tdata[MODE_W-1:0];
    assign s_value  = s_tdata[MODE_W+DATA_W-1:MODE_W];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign last_idx = AW'(count_reg - CW'(1));
    assign out_free = !m_valid_reg || m_tready;

    // The one comparator of the sort: does the entry below the hole beat the key?
    assign above_key = $signed(mem_rdata) > key_reg;

    sstk_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        key_next     = key_reg;
        res_next     = res_reg;
        st_next      = st_reg;
        m_valid_next = m_valid_reg;
        out_res_next = out_res_reg;
        out_st_next  = out_st_reg;
        out_cnt_next = out_cnt_reg;
        mem_we       = 1'b0;
        mem_waddr    = j_reg;
        mem_wdata    = key_reg;
        mem_raddr    = last_idx;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    res_next = '0;
                    st_next  = ST_OK;
                    case (s_mode)
                        MODE_PUSH: begin
                            state_next = S_RESP;
                            if (count_reg == CW'(DEPTH)) begin
                                st_next = ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = s_value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        MODE_POP, MODE_PEEK: begin
                            if (count_reg == '0) begin
                                res_next   = NEG_ONE;
                                st_next    = ST_EMPTY;
                                state_next = S_RESP;
                            end else begin
                                mem_raddr  = last_idx;
                                state_next = S_POP_RD;
                                if (s_mode == MODE_POP) begin
                                    count_next = count_reg - CW'(1);
                                end
                            end
                        end
                        MODE_SORT: begin
                            if (count_reg < CW'(2)) begin
                                state_next = S_RESP;
                            end else begin
                                i_next     = AW'(1);
                                mem_raddr  = AW'(1);
                                state_next = S_KEY_LD;
                            end
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_POP_RD: begin
                res_next   = mem_rdata;
                state_next = S_RESP;
            end
            S_KEY_LD: begin
                key_next   = mem_rdata;
                j_next     = i_reg;
                mem_raddr  = i_reg - AW'(1);
                state_next = S_CMP;
            end
            S_CMP: begin
                mem_we = 1'b1;
                if (above_key) begin
                    // Shift the larger entry up one place and keep walking down.
                    mem_wdata = mem_rdata;
                    j_next    = j_reg - AW'(1);
                    if (j_reg == AW'(1)) begin
                        state_next = S_PLACE;
                    end else begin
                        mem_raddr = j_reg - AW'(2);
                    end
                end else begin
                    mem_wdata = key_reg;
                    if (i_reg == last_idx) begin
                        state_next = S_RESP;
                    end else begin
                        i_next     = i_reg + AW'(1);
                        mem_raddr  = i_reg + AW'(1);
                        state_next = S_KEY_LD;
                    end
                end
            end
            S_PLACE: begin
                // The key reached the bottom of the stack.
                mem_we    = 1'b1;
                mem_wdata = key_reg;
                if (i_reg == last_idx) begin
                    state_next = S_RESP;
                end else begin
                    i_next     = i_reg + AW'(1);
                    mem_raddr  = i_reg + AW'(1);
                    state_next = S_KEY_LD;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    out_res_next = res_reg;
                    out_st_next  = st_reg;
                    out_cnt_next = COUNT_W'(count_reg);
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        key_reg     <= key_next;
        res_reg     <= res_next;
        st_reg      <= st_next;
        out_res_reg <= out_res_next;
        out_st_reg  <= out_st_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_cnt_reg, out_st_reg, out_res_reg};

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(DEPTH),
        "entry count exceeds the store depth")
    `ASSERT_IMPLY(a_hole_range, state_reg == S_CMP,
        (j_reg != '0) && (j_reg <= i_reg) && (i_reg <= last_idx),
        "insertion hole out of range during sort")
    `ASSERT_IMPLY(a_sort_count, state_reg == S_CMP || state_reg == S_PLACE,
        $stable(count_reg), "entry count changed during sort")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sortable stack unit testbench
// Sends push, pop, peek and sort operations with random gaps and random
// result back-pressure. A behavioral stack in the bench predicts each result
// when its operation transfer is accepted. Every result transfer is then
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb
    import sstk_pkg::*;
();

    localparam int DEPTH       = 16;
    localparam int RAND_OPS    = 1800;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int TAIL_CYCLES = 200;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] value;
    } stack_op_t;

    typedef struct packed {
        logic [DATA_W-1:0]  value;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] count;
    } stack_reply_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    stack_op_t    op_q[$];
    stack_reply_t reply_q[$];
    stack_op_t    cur_op = '0;
    bit           op_busy = 1'b0;

    // Shadow copy of the stack contents, bottom at index 0.
    logic signed [DATA_W-1:0] held [DEPTH];
    int held_n = 0;

    int send_gap    = 0;
    int recv_stall  = 0;
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;
    int desc_next   = 0;
    int fail_count  = 0;
    int cycle_count = 0;

    sortable_stack_unit #(
        .DEPTH(DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic stack_reply_t apply_stack_op(input stack_op_t op);
        stack_reply_t r;
        logic signed [DATA_W-1:0] key;
        int j;
        r.value  = '0;
        r.status = ST_OK;
        case (op.mode)
            MODE_PUSH: begin
                if (held_n >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    held[held_n] = op.value;
                    held_n++;
                end
            end
            MODE_POP: begin
                if (held_n == 0) begin
                    r.value  = NEG_ONE;
                    r.status = ST_EMPTY;
                end else begin
                    held_n--;
                    r.value = held[held_n];
                end
            end
            MODE_PEEK: begin
                if (held_n == 0) begin
                    r.value  = NEG_ONE;
                    r.status = ST_EMPTY;
                end else begin
                    r.value = held[held_n - 1];
                end
            end
            default: begin
                // Ascending from the bottom, so the largest value ends on top.
                for (int i = 1; i < held_n; i++) begin
                    key = held[i];
                    j = i;
                    while (j > 0 && held[j - 1] > key) begin
                        held[j] = held[j - 1];
                        j--;
                    end
                    held[j] = key;
                end
            end
        endcase
        r.count = COUNT_W'(held_n);
        return r;
    endfunction

    // Mostly short gaps, now and then a long one; none during a steady stretch.
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value(input int vstyle);
        logic [DATA_W-1:0] v;
        case (vstyle)
            0: begin
                v = $urandom;
            end
            1: begin
                // Narrow range so that sorts see many equal values.
                v = $urandom_range(0, 8) - 4;
            end
            2: begin
                // Falling values give the sort its longest walk.
                v = desc_next;
                desc_next = desc_next - int'($urandom_range(1, 1000));
            end
            default: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7fff_ffff;
                    2:       v = '0;
                    3:       v = '1;
                    default: v = 32'd1;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic add_op(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value);
        stack_op_t op;
        op.mode  = mode;
        op.value = value;
        op_q.push_back(op);
    endtask

    // Runs of operations lean toward filling, draining or holding the level.
    task automatic add_random_ops(input int n);
        int left;
        int run_len;
        int bias;
        int vstyle;
        int r;
        logic [MODE_W-1:0] mode;
        left = n;
        while (left > 0) begin
            run_len   = $urandom_range(8, 40);
            bias      = $urandom_range(0, 2);
            vstyle    = $urandom_range(0, 3);
            desc_next = $urandom;
            for (int k = 0; k < run_len && left > 0; k++) begin
                r = $urandom_range(0, 99);
                case (bias)
                    0: begin
                        mode = r < 70 ? MODE_PUSH : r < 80 ? MODE_POP :
                               r < 88 ? MODE_PEEK : MODE_SORT;
                    end
                    1: begin
                        mode = r < 25 ? MODE_PUSH : r < 70 ? MODE_POP :
                               r < 85 ? MODE_PEEK : MODE_SORT;
                    end
                    default: begin
                        mode = r < 40 ? MODE_PUSH : r < 65 ? MODE_POP :
                               r < 80 ? MODE_PEEK : MODE_SORT;
                    end
                endcase
                if (mode == MODE_PUSH) begin
                    add_op(mode, pick_value(vstyle));
                end else begin
                    add_op(mode, $urandom);
                end
                left--;
            end
        end
    endtask

    task automatic wait_drained();
        while (op_q.size() != 0 || op_busy || reply_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Operation driver: predicts each result at the transfer that accepts it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            op_busy = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                reply_q.push_back(apply_stack_op(cur_op));
                op_busy = 1'b0;
                send_gap = pick_gap(send_steady);
                if ($urandom_range(0, 99) < 3) begin
                    send_steady = !send_steady;
                end
            end
            if (!op_busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (op_q.size() != 0) begin
                    cur_op = op_q.pop_front();
                    op_busy = 1'b1;
                end
            end
            s_tvalid <= op_busy;
            s_tdata  <= {6'b0, cur_op.value, cur_op.mode};
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge aclk) begin
        stack_reply_t got;
        stack_reply_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.value  = m_tdata[31:0];
                got.status = m_tdata[33:32];
                got.count  = m_tdata[38:34];
                if (reply_q.size() == 0) begin
                    $error("result transfer with no operation outstanding");
                    fail_count++;
                end else begin
                    want = reply_q.pop_front();
                    if (got.value !== want.value) begin
                        $error("result_value: expected %0d, got %0d",
                               $signed(want.value), $signed(got.value));
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.count !== want.count) begin
                        $error("entry_count: expected %0d, got %0d", want.count, got.count);
                        fail_count++;
                    end
                end
            end
            if ($urandom_range(0, 99) < 1) begin
                recv_steady = !recv_steady;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < 20) begin
                    recv_stall = pick_gap(recv_steady);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty stack, single entry, extremes and duplicates.
        add_op(MODE_POP,  32'hdead_beef);
        add_op(MODE_PEEK, 32'h1234_5678);
        add_op(MODE_SORT, 32'hffff_ffff);
        add_op(MODE_PUSH, 32'h7fff_ffff);
        add_op(MODE_SORT, 32'h0000_0000);
        add_op(MODE_PEEK, 32'h0000_0000);
        add_op(MODE_POP,  32'h0000_0000);
        add_op(MODE_PUSH, 32'h8000_0000);
        add_op(MODE_PUSH, 32'hffff_ffff);
        add_op(MODE_PUSH, 32'h0000_0000);
        add_op(MODE_PUSH, 32'h7fff_ffff);
        add_op(MODE_PUSH, 32'h0000_0001);
        add_op(MODE_PUSH, 32'hffff_ffff);
        add_op(MODE_SORT, 32'h5555_5555);
        add_op(MODE_PEEK, 32'haaaa_aaaa);
        add_op(MODE_POP,  32'h0000_0000);
        add_op(MODE_POP,  32'h0000_0000);
        wait_drained();

        add_random_ops(RAND_OPS / 2);
        // Hold the sender off until every outstanding result has come back.
        wait_drained();
        add_random_ops(RAND_OPS - RAND_OPS / 2);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/sstk_pkg.sv
hdl/sstk_ram.sv
hdl/sortable_stack_unit.sv
tb/tb.sv
